>>> hw/rtl/rfft_pkg.sv
// Package for the radix-2 FFT: widths, controller commands, twiddle table.
// No dependencies.
`timescale 1ns / 1ps
package rfft_pkg;
  localparam int SampleW = 16;
  localparam int TwW = 16;
  localparam int WorkW = 23;
  localparam int AddrW = 6;
  localparam int MaxLog = 6;
  localparam int IterW = 5;

  typedef struct packed {
    logic            load;     // write input sample
    logic [AddrW-1:0] load_addr;
    logic            rd;       // read pair for butterfly
    logic [AddrW-1:0] rd_e;
    logic [AddrW-1:0] rd_o;
    logic [IterW-1:0] tw_m;
    logic            wr;       // write butterfly result
    logic [AddrW-1:0] wr_e;
    logic [AddrW-1:0] wr_o;
    logic            emit_rd;  // read one bin
    logic [AddrW-1:0] emit_addr;
  } rfft_cmd_t;

  // cos(2*pi*m/64) rounded to Q1.15, m = 0..16, +1.0 saturated
  function automatic logic signed [TwW-1:0] cos_q(input logic [4:0] m);
    logic signed [TwW-1:0] r;
    case (m)
      5'd0: r = 16'sd32767;   5'd1: r = 16'sd32610;  5'd2: r = 16'sd32138;
      5'd3: r = 16'sd31357;   5'd4: r = 16'sd30274;  5'd5: r = 16'sd28899;
      5'd6: r = 16'sd27246;   5'd7: r = 16'sd25330;  5'd8: r = 16'sd23170;
      5'd9: r = 16'sd20788;   5'd10: r = 16'sd18205; 5'd11: r = 16'sd15447;
      5'd12: r = 16'sd12540;  5'd13: r = 16'sd9512;  5'd14: r = 16'sd6393;
      5'd15: r = 16'sd3212;   5'd16: r = 16'sd0;
      default: r = 16'sd0;
    endcase
    return r;
  endfunction
endpackage

>>> hw/rtl/rfft_ctrl.sv
// Controller for the radix-2 FFT: load, butterfly sequencing and bin emission.
// Depends on rfft_pkg.
`timescale 1ns / 1ps
module rfft_ctrl
  import rfft_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [2:0] cfg_data,
  input  logic       in_xfer,
  output logic       in_ready,
  input  logic       emit_space,
  output logic       emit_valid,
  output logic [AddrW-1:0] emit_index,
  output logic       emit_last,
  output rfft_cmd_t  cmd
);
  localparam logic [1:0] ST_LOAD = 2'd0;
  localparam logic [1:0] ST_BFLY = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]   state;
  logic [2:0]   lp;
  logic [AddrW:0] load_count;
  logic [2:0]   stage;      // 1..lp
  logic [AddrW-1:0] bf;     // butterfly counter within stage
  logic [AddrW-1:0] ek;     // emit counter
  logic         rd_pend;    // read issued, write next cycle
  logic [AddrW-1:0] pe, po;
  logic         ev1;        // emit read in flight
  logic [AddrW-1:0] ek1;
  logic         el1;

  logic [AddrW-1:0] nmask, rev, half, jj, e_addr, o_addr, ri;
  logic [AddrW:0]   nbf;

  always_comb begin
    nmask = AddrW'((7'd1 << lp) - 7'd1);
    ri = '0;
    for (int b = 0; b < MaxLog; b++) begin
      if (b < lp) ri[lp - 3'd1 - 3'(b)] = load_count[b];
    end
    rev = ri;
    half = AddrW'(7'd1 << (stage - 3'd1));
    jj = bf & (half - 1'b1);
    e_addr = ((bf & ~(half - 1'b1)) << 1) | jj;
    o_addr = e_addr | half;
    nbf = 7'((7'd1 << lp) >> 1);
  end

  assign in_ready = (state == ST_LOAD) && !cfg_we;

  // command outputs
  always_comb begin
    cmd = '0;
    cmd.load = in_xfer;
    cmd.load_addr = rev;
    cmd.rd = (state == ST_BFLY) && !rd_pend;
    cmd.rd_e = e_addr;
    cmd.rd_o = o_addr;
    cmd.tw_m = IterW'(jj << (3'd6 - stage));
    cmd.wr = rd_pend;
    cmd.wr_e = pe;
    cmd.wr_o = po;
    cmd.emit_rd = (state == ST_EMIT) && emit_space && !ev1;
    cmd.emit_addr = ek;
  end

  assign emit_valid = ev1;
  assign emit_index = ek1;
  assign emit_last = el1;

  // sequence the phases
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD; lp <= 3'd6; load_count <= '0; rd_pend <= 1'b0;
      ev1 <= 1'b0; stage <= 3'd1; bf <= '0; ek <= '0;
    end else begin
      ev1 <= cmd.emit_rd;
      ek1 <= ek;
      el1 <= (ek == nmask);
      if (cfg_we) begin
        lp <= (cfg_data > 3'd6) ? 3'd6 : cfg_data;
        load_count <= '0;
      end
      case (state)
        ST_LOAD: if (in_xfer) begin
          if (load_count == {1'b0, nmask}) begin
            load_count <= '0;
            stage <= 3'd1; bf <= '0; ek <= '0;
            state <= (lp == 3'd0) ? ST_EMIT : ST_BFLY;
          end else begin
            load_count <= load_count + 1'b1;
          end
        end
        ST_BFLY: begin
          rd_pend <= !rd_pend;
          if (!rd_pend) begin
            pe <= e_addr; po <= o_addr;
          end else if ({1'b0, bf} == nbf - 1'b1) begin
            bf <= '0;
            if (stage == lp) state <= ST_EMIT;
            else stage <= stage + 1'b1;
          end else begin
            bf <= bf + 1'b1;
          end
        end
        ST_EMIT: if (cmd.emit_rd) begin
          if (ek == nmask) begin
            ek <= '0; state <= ST_LOAD;
          end else begin
            ek <= ek + 1'b1;
          end
        end
        default: state <= ST_LOAD;
      endcase
    end
  end
endmodule

>>> hw/rtl/rfft_dp.sv
// Datapath for the radix-2 FFT: work memory, twiddle lookup and butterfly.
// Depends on rfft_pkg.
`timescale 1ns / 1ps
module rfft_dp
  import rfft_pkg::*;
(
  input  logic clk,
  input  rfft_cmd_t cmd,
  input  logic signed [SampleW-1:0] in_re,
  input  logic signed [SampleW-1:0] in_im,
  output logic signed [WorkW-1:0] bin_re,
  output logic signed [WorkW-1:0] bin_im
);
  logic signed [WorkW-1:0] mre [0:63];
  logic signed [WorkW-1:0] mim [0:63];
  logic signed [WorkW-1:0] er, ei, or_, oi;
  logic signed [TwW-1:0] wr, wi, c, s;
  logic [4:0] m;
  logic [AddrW-1:0] ra;
  logic signed [40:0] pr, pi;
  logic signed [WorkW+1:0] tr, ti, ar, ai, br, bi;
  logic signed [WorkW-1:0] sar, sai, sbr, sbi;

  function automatic logic signed [WorkW-1:0] sat(input logic signed [WorkW+1:0] v);
    if (v > 25'sd4194303) return 23'sh3FFFFF;
    if (v < -25'sd4194304) return 23'sh400000;
    return v[WorkW-1:0];
  endfunction

  // twiddle for the butterfly read this cycle
  always_comb begin
    m = cmd.tw_m;
    if (m <= 5'd16) begin
      c = cos_q(m); s = cos_q(5'd16 - m);
    end else begin
      c = -cos_q(5'd0 - m); s = cos_q(m - 5'd16);
    end
  end

  // share the first read port between the even term and bin emission
  assign ra = cmd.emit_rd ? cmd.emit_addr : cmd.rd_e;

  // read pair and twiddle register
  always_ff @(posedge clk) begin
    if (cmd.rd || cmd.emit_rd) begin
      er <= mre[ra]; ei <= mim[ra];
    end
    if (cmd.rd) begin
      or_ <= mre[cmd.rd_o]; oi <= mim[cmd.rd_o];
      wr <= c; wi <= -s;
    end
  end

  assign bin_re = er;
  assign bin_im = ei;

  // rotate the odd term, round, add and subtract
  always_comb begin
    pr = 41'(wr * or_) - 41'(wi * oi) + 41'sd16384;
    pi = 41'(wr * oi) + 41'(wi * or_) + 41'sd16384;
    tr = 25'(pr >>> 15);
    ti = 25'(pi >>> 15);
    ar = 25'(er) + tr; ai = 25'(ei) + ti;
    br = 25'(er) - tr; bi = 25'(ei) - ti;
    sar = sat(ar); sai = sat(ai); sbr = sat(br); sbi = sat(bi);
  end

  // write the work memory
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mre[cmd.load_addr] <= WorkW'(in_re); mim[cmd.load_addr] <= WorkW'(in_im);
    end else if (cmd.wr) begin
      mre[cmd.wr_e] <= sar; mim[cmd.wr_e] <= sai;
      mre[cmd.wr_o] <= sbr; mim[cmd.wr_o] <= sbi;
    end
  end
endmodule

>>> hw/rtl/radix2_fft_top.sv
// Top level of the radix-2 FFT: stream ports, output register, assertions.
// Depends on rfft_pkg, rfft_ctrl and rfft_dp.
//
// channel   direction  fields (low bit first)
// s_axis    in         tdata: sample_re[15:0], sample_im[31:16]
// m_axis    out        tdata: bin_re[22:0], bin_im[45:23], bin_index[51:46], pad
//                      tlast: last_bin
// cfg       in         cfg_we / cfg_data: log_points
//
// A frame loads N samples, runs (N/2)*log2(N) butterflies (each reads the
// even and odd terms, then writes both results) and emits N bins, one bin
// read in flight at a time. Input is refused while transforming or emitting.
// Synchronous reset returns to loading with log_points 6. Output stalls hold.
`timescale 1ns / 1ps
module radix2_fft_top
  import rfft_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // sample_re, sample_im
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // bin_re, bin_im, bin_index
  output logic        m_axis_tlast    // last_bin
);
  rfft_cmd_t cmd;
  logic in_xfer, ev, el, space;
  logic [AddrW-1:0] ei;
  logic signed [WorkW-1:0] br, bi;

  assign in_xfer = s_axis_tvalid && s_axis_tready;
  assign space = !m_axis_tvalid || m_axis_tready;

  rfft_ctrl u_ctrl (.clk, .rst, .cfg_we, .cfg_data, .in_xfer, .in_ready(s_axis_tready),
    .emit_space(space), .emit_valid(ev), .emit_index(ei), .emit_last(el), .cmd);

  rfft_dp u_dp (.clk, .cmd, .in_re(s_axis_tdata[15:0]), .in_im(s_axis_tdata[31:16]),
    .bin_re(br), .bin_im(bi));

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (ev) begin
      m_axis_tvalid <= 1'b1;
      m_axis_tdata <= {4'd0, ei, bi, br};
      m_axis_tlast <= el;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_no_in_during_out: assert property (@(posedge clk) disable iff (rst)
    (ev && !el) |-> !s_axis_tready) else $error("input open while emitting");
  a_emit_space: assert property (@(posedge clk) disable iff (rst)
    ev |-> !(m_axis_tvalid && !m_axis_tready)) else $error("emit into full register");
  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    !(cmd.load && cmd.wr)) else $error("load during butterfly write");
`endif
endmodule
